// File: hw/rtl/json_string_unescape_assert.svh
// assertion macros used by the json string unescape rtl
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jsu_pkg.sv
// types, codes and helper functions of the json string unescaper
package jsu_pkg;

    localparam int CNT_W       = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // surrogate ranges
    localparam logic [15:0] SURR_HI_MIN = 16'hd800;
    localparam logic [15:0] SURR_HI_MAX = 16'hdbff;
    localparam logic [15:0] SURR_LO_MIN = 16'hdc00;
    localparam logic [15:0] SURR_LO_MAX = 16'hdfff;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    localparam logic [CNT_W-1:0] MAX_LEN_RESET = 13'd4096;

    typedef enum logic [3:0] {
        PH_QUOTE = 4'd0,
        PH_STR   = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEX   = 4'd3,
        PH_BSL   = 4'd4,
        PH_U     = 4'd5,
        PH_LOW   = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        RES_BYTE   = 2'd0,
        RES_CLOSED = 2'd1,
        RES_ERROR  = 2'd2
    } t_res_kind;

    typedef enum logic [3:0] {
        ERR_NO_QUOTE    = 4'd0,
        ERR_CONTROL     = 4'd1,
        ERR_TRUNC_ESC   = 4'd2,
        ERR_BAD_HEX     = 4'd3,
        ERR_MISSING_LOW = 4'd4,
        ERR_BAD_LOW     = 4'd5,
        ERR_LONE_LOW    = 4'd6,
        ERR_UNSUPPORTED = 4'd7,
        ERR_TOO_LONG    = 4'd8,
        ERR_UNTERM      = 4'd9
    } t_err;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        t_res_kind        res_kind;
        logic [7:0]       out_byte;
        t_err             error_code;
        logic [CNT_W-1:0] byte_count;
        logic             last_of_run;
    } t_res_word;

    // one group of results caused by one input byte
    typedef struct packed {
        t_res_kind        kind;
        logic [1:0]       last_idx;
        logic [3:0][7:0]  bytes;
        t_err             error_code;
        logic [CNT_W-1:0] byte_count;
    } t_grp;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } t_utf8;

    typedef struct packed {
        logic       ok;
        logic [3:0] d;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok = 1'b1;
        h.d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.d = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.d = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.d = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.n = 3'd0;
        u.b = '0;
        if (cp <= 21'h7f) begin
            u.n    = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            u.n    = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            u.n    = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.n    = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

// File: hw/rtl/jsu_front.sv
// front end: takes raw bytes, runs the string parser and emits result groups
module jsu_front #(
    parameter int LIMIT_CAP = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [jsu_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                    i_accept,
    input  jsu_pkg::t_in_word       i_word,
    output logic                    o_enq,
    output jsu_pkg::t_grp           o_grp
);
    import jsu_pkg::*;

    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(LIMIT_CAP);

    t_phase           r_phase, n_phase;
    logic [15:0]      r_acc, n_acc;
    logic [1:0]       r_dcnt, n_dcnt;
    logic [9:0]       r_hs, n_hs;
    logic [CNT_W-1:0] r_ocnt;
    logic [CNT_W-1:0] r_max_len;

    logic [7:0]       b;
    logic             eoi;
    t_hex             hv;
    logic [15:0]      acc_next;
    logic             do_enc;
    logic [20:0]      enc_cp;
    t_utf8            enc;
    logic [2:0]       nb;
    logic [3:0][7:0]  bytes;
    logic             closed;
    logic             err;
    t_err             ecode;
    logic [CNT_W-1:0] limit;
    logic [CNT_W:0]   sum;
    logic             grp_valid;

    assign b        = i_word.in_byte;
    assign eoi      = i_word.end_of_input;
    assign hv       = hex_decode(b);
    assign acc_next = {r_acc[11:0], hv.d};
    assign limit    = (r_max_len < CAP_V) ? r_max_len : CAP_V;

    // parser step for the byte on the input
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_dcnt  = r_dcnt;
        n_hs    = r_hs;
        err     = 1'b0;
        ecode   = ERR_NO_QUOTE;
        closed  = 1'b0;
        do_enc  = 1'b0;
        enc_cp  = {5'd0, acc_next};
        nb      = 3'd0;
        bytes   = '0;
        case (r_phase)
            PH_STR: begin
                if (b == CH_QUOTE) begin
                    closed = 1'b1;
                end else if (b < CH_SPACE) begin
                    err   = 1'b1;
                    ecode = ERR_CONTROL;
                end else if (b == CH_BSL) begin
                    if (eoi) begin
                        err   = 1'b1;
                        ecode = ERR_TRUNC_ESC;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end else begin
                    nb       = 3'd1;
                    bytes[0] = b;
                end
            end
            PH_ESC: begin
                n_phase = PH_STR;
                nb      = 3'd1;
                case (b)
                    CH_QUOTE, CH_BSL, CH_SLASH: bytes[0] = b;
                    CH_B: bytes[0] = 8'h08;
                    CH_F: bytes[0] = 8'h0c;
                    CH_N: bytes[0] = 8'h0a;
                    CH_R: bytes[0] = 8'h0d;
                    CH_T: bytes[0] = 8'h09;
                    CH_U: begin
                        nb      = 3'd0;
                        n_phase = PH_HEX;
                        n_acc   = 16'd0;
                        n_dcnt  = 2'd0;
                        if (eoi) begin
                            err   = 1'b1;
                            ecode = ERR_BAD_HEX;
                        end
                    end
                    default: begin
                        nb    = 3'd0;
                        err   = 1'b1;
                        ecode = ERR_UNSUPPORTED;
                    end
                endcase
            end
            PH_HEX: begin
                if (!hv.ok) begin
                    err   = 1'b1;
                    ecode = ERR_BAD_HEX;
                end else begin
                    n_acc = acc_next;
                    if (r_dcnt == 2'd3) begin
                        n_dcnt = 2'd0;
                        if (acc_next >= SURR_HI_MIN && acc_next <= SURR_HI_MAX) begin
                            n_hs    = acc_next[9:0];
                            n_phase = PH_BSL;
                            if (eoi) begin
                                err   = 1'b1;
                                ecode = ERR_MISSING_LOW;
                            end
                        end else if (acc_next >= SURR_LO_MIN && acc_next <= SURR_LO_MAX) begin
                            err   = 1'b1;
                            ecode = ERR_LONE_LOW;
                        end else begin
                            do_enc  = 1'b1;
                            n_phase = PH_STR;
                        end
                    end else begin
                        n_dcnt = r_dcnt + 2'd1;
                        if (eoi) begin
                            err   = 1'b1;
                            ecode = ERR_BAD_HEX;
                        end
                    end
                end
            end
            PH_BSL: begin
                if (b != CH_BSL || eoi) begin
                    err   = 1'b1;
                    ecode = ERR_MISSING_LOW;
                end else begin
                    n_phase = PH_U;
                end
            end
            PH_U: begin
                if (b != CH_U) begin
                    err   = 1'b1;
                    ecode = ERR_MISSING_LOW;
                end else begin
                    n_phase = PH_LOW;
                    n_acc   = 16'd0;
                    n_dcnt  = 2'd0;
                    if (eoi) begin
                        err   = 1'b1;
                        ecode = ERR_BAD_LOW;
                    end
                end
            end
            PH_LOW: begin
                if (!hv.ok) begin
                    err   = 1'b1;
                    ecode = ERR_BAD_LOW;
                end else begin
                    n_acc = acc_next;
                    if (r_dcnt == 2'd3) begin
                        n_dcnt = 2'd0;
                        if (acc_next < SURR_LO_MIN || acc_next > SURR_LO_MAX) begin
                            err   = 1'b1;
                            ecode = ERR_BAD_LOW;
                        end else begin
                            do_enc  = 1'b1;
                            enc_cp  = SUPP_BASE + {1'b0, r_hs, acc_next[9:0]};
                            n_phase = PH_STR;
                        end
                    end else begin
                        n_dcnt = r_dcnt + 2'd1;
                        if (eoi) begin
                            err   = 1'b1;
                            ecode = ERR_BAD_LOW;
                        end
                    end
                end
            end
            default: begin
                // awaiting the opening quote, unused codes too
                n_acc  = 16'd0;
                n_dcnt = 2'd0;
                n_hs   = 10'd0;
                if (b == CH_QUOTE) begin
                    n_phase = PH_STR;
                    if (eoi) begin
                        err   = 1'b1;
                        ecode = ERR_UNTERM;
                    end
                end else begin
                    n_phase = PH_QUOTE;
                    err     = 1'b1;
                    ecode   = ERR_NO_QUOTE;
                end
            end
        endcase

        enc = utf8_encode(enc_cp);
        if (do_enc) begin
            nb    = enc.n;
            bytes = enc.b;
        end

        // length limit first, then the end of input inside a string
        sum = {1'b0, r_ocnt} + {{(CNT_W - 2){1'b0}}, nb};
        if (!err && nb != 3'd0 && sum > {1'b0, limit}) begin
            err   = 1'b1;
            ecode = ERR_TOO_LONG;
        end
        if (!err && !closed && eoi) begin
            err   = 1'b1;
            ecode = ERR_UNTERM;
        end
    end

    // result group for the queue
    assign grp_valid = err || closed || (nb != 3'd0);
    assign o_enq     = i_accept && grp_valid;

    always_comb begin
        o_grp            = '0;
        o_grp.error_code = ERR_NO_QUOTE;
        if (err) begin
            o_grp.kind       = RES_ERROR;
            o_grp.error_code = ecode;
        end else if (closed) begin
            o_grp.kind       = RES_CLOSED;
            o_grp.byte_count = r_ocnt;
        end else begin
            o_grp.kind     = RES_BYTE;
            o_grp.last_idx = 2'(nb - 3'd1);
            o_grp.bytes    = bytes;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_QUOTE;
            r_acc   <= 16'd0;
            r_dcnt  <= 2'd0;
            r_hs    <= 10'd0;
            r_ocnt  <= '0;
        end else if (i_accept) begin
            if (err || closed) begin
                r_phase <= PH_QUOTE;
                r_acc   <= 16'd0;
                r_dcnt  <= 2'd0;
                r_hs    <= 10'd0;
                r_ocnt  <= '0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_dcnt  <= n_dcnt;
                r_hs    <= n_hs;
                r_ocnt  <= CNT_W'(sum);
            end
        end
    end

    // length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

endmodule

// File: hw/rtl/jsu_queue.sv
// short queue of result groups between the front and back ends
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enq,
    input  jsu_pkg::t_grp i_grp,
    input  logic          i_deq,
    output jsu_pkg::t_grp o_head,
    output logic          o_empty,
    output logic          o_full
);
    import jsu_pkg::*;

    `include "json_string_unescape_assert.svh"

    t_grp              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    // group storage
    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wptr] <= i_grp;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_enq) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_deq) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_enq, i_deq})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `JSU_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_enq, !o_full, "write into full queue")
    `JSU_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_deq, !o_empty, "read from empty queue")
    `JSU_ASSERT_NEXT(a_fill_step, i_clk, i_rst_n, i_enq && !i_deq,
                     r_count == $past(r_count) + 1'b1, "fill level did not rise on write")

endmodule

// File: hw/rtl/jsu_back.sv
// back end: splits each queued group into result words, one per cycle while pop is high
module jsu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jsu_pkg::t_grp     i_head,
    input  logic              i_head_empty,
    input  logic              i_pop,
    output logic              o_deq,
    output jsu_pkg::t_res_word o_word
);
    import jsu_pkg::*;

    logic [1:0] r_sub;
    logic       last;

    assign last  = (r_sub == i_head.last_idx);
    assign o_deq = i_pop && !i_head_empty && last;

    // result word from the head group
    always_comb begin
        o_word             = '0;
        o_word.res_kind    = i_head.kind;
        o_word.error_code  = i_head.error_code;
        o_word.byte_count  = i_head.byte_count;
        o_word.last_of_run = last;
        o_word.out_byte    = (i_head.kind == RES_BYTE) ? i_head.bytes[r_sub] : 8'd0;
    end

    // position inside the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else if (i_pop && !i_head_empty) begin
            r_sub <= last ? 2'd0 : r_sub + 2'd1;
        end
    end

endmodule

// File: hw/rtl/json_string_unescape.sv
// top level of the json string unescaper
//
// Takes one raw byte per cycle, starting at the opening quote of a json string, and
// returns the unescaped text as utf-8 words, then a closed word with the byte count,
// or a single error word. Input is taken every cycle while full is low; each byte
// that causes results writes one group into a four-entry queue, and the back end
// hands out one result word per cycle while pop is high, so a \u escape that expands
// to up to four bytes drains over as many pops while input keeps flowing. A result
// is registered in the queue before it shows on the output. There is no clearing
// pass after reset. The per-string byte limit is the smaller of the configured
// register and MAX_STRING_BYTES.
module json_string_unescape #(
    parameter int MAX_STRING_BYTES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [jsu_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  jsu_pkg::t_in_word         i_word,
    output logic                      empty,
    input  logic                      pop,
    output jsu_pkg::t_res_word        o_word
);
    import jsu_pkg::*;

    localparam int CNT_MAX   = (1 << CNT_W) - 1;
    localparam int LIMIT_CAP = (MAX_STRING_BYTES > CNT_MAX) ? CNT_MAX : MAX_STRING_BYTES;

    logic accept;
    logic enq;
    logic deq;
    t_grp grp;
    t_grp head;

    assign accept = push && !full;

    jsu_front #(
        .LIMIT_CAP (LIMIT_CAP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_word      (i_word),
        .o_enq       (enq),
        .o_grp       (grp)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_grp   (grp),
        .i_deq   (deq),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (empty),
        .i_pop        (pop),
        .o_deq        (deq),
        .o_word       (o_word)
    );

endmodule
